[design/plf_pkg.sv]
package plf_pkg;

   // CORDIC iteration count; the arctangent table holds 24 steps at most
   localparam int ROTATION_STEPS = 16;
   localparam int ATAN_ENTRIES   = 24;
   localparam int CORDIC_STAGES  = (ROTATION_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES
                                                                    : ROTATION_STEPS;

   // 1/K in Q2.30, so the rotation leaves a unit vector
   localparam logic signed [31:0] CORDIC_GAIN_INV = 32'sh26DD3B6A;

   // atan(2^-i) as a 32-bit binary angle (2^32 = 2 pi)
   localparam logic signed [31:0] ATAN_TABLE [ATAN_ENTRIES] = '{
      32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
      32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
      32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
      32'sd166886,    32'sd83443,     32'sd41721,     32'sd20860,
      32'sd10430,     32'sd5215,      32'sd2607,      32'sd1303,
      32'sd651,       32'sd325,       32'sd162,       32'sd81
   };

   typedef enum logic {
      CMD_TO_LOCAL = 1'b0,
      CMD_TO_WORLD = 1'b1
   } command_type;

   // operands that ride alongside the rotator
   typedef struct packed {
      logic               to_world;
      logic signed [32:0] opnd_a;
      logic signed [32:0] opnd_b;
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
   } item_type;

endpackage

[design/planar_frame_transform.sv]
// channel   direction  handshake             payload
// request   in         start & !busy         req_command, req_point_x/y, req_origin_x/y,
//                                            req_origin_angle
// result    out        rsp_valid (1 cycle)   rsp_result_x, rsp_result_y, rsp_overflow
//
// One request per cycle; each result passes through load, one CORDIC stage per step,
// sign fix, multiply, sum/round and origin/saturate before it appears.
// busy follows reset only: the pipeline never stops, as results cannot be held off.
// Synchronous reset clears the valid bits; data registers are not reset.
module planar_frame_transform (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_command,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_origin_x,
   input  logic signed [31:0] req_origin_y,
   input  logic signed [15:0] req_origin_angle,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_result_x,
   output logic signed [31:0] rsp_result_y,
   output logic               rsp_overflow
);
   import plf_pkg::*;

   localparam logic signed [36:0] SAT_MAX = 37'sd2147483647;
   localparam logic signed [36:0] SAT_MIN = -37'sd2147483648;
   localparam logic signed [65:0] ROUND_HALF = 66'sd536870912;

   logic               req_accept;
   logic               to_world;
   item_type           req_item;

   logic               cd_valid;
   logic signed [31:0] cd_cos, cd_sin;
   item_type           cd_item;

   // multiply stage
   logic               mul_valid_ff, mul_valid_in;
   logic               mul_world_ff;
   logic signed [31:0] mul_ox_ff, mul_oy_ff;
   logic signed [64:0] prod_ac_ff, prod_ac_in;
   logic signed [64:0] prod_bs_ff, prod_bs_in;
   logic signed [64:0] prod_as_ff, prod_as_in;
   logic signed [64:0] prod_bc_ff, prod_bc_in;

   // sum and round stage
   logic               sum_valid_ff, sum_valid_in;
   logic               sum_world_ff;
   logic signed [31:0] sum_ox_ff, sum_oy_ff;
   logic signed [65:0] sum_x, sum_y, rnd_x, rnd_y;
   logic signed [35:0] rnd_x_ff, rnd_x_in;
   logic signed [35:0] rnd_y_ff, rnd_y_in;

   // origin and saturate stage
   logic signed [36:0] ext_x, ext_y;
   logic               ovf_x, ovf_y;
   logic               out_valid_ff, out_valid_in;
   logic signed [31:0] out_x_ff, out_x_in;
   logic signed [31:0] out_y_ff, out_y_in;
   logic               out_ovf_ff, out_ovf_in;

   assign busy       = reset;
   assign req_accept = start & ~busy;
   assign to_world   = (req_command == CMD_TO_WORLD);

   // world to local works on the difference, exact in 33 bits
   always_comb begin
      req_item.to_world = to_world;
      req_item.origin_x = req_origin_x;
      req_item.origin_y = req_origin_y;
      if (to_world) begin
         req_item.opnd_a = 33'(req_point_x);
         req_item.opnd_b = 33'(req_point_y);
      end else begin
         req_item.opnd_a = 33'(req_point_x) - 33'(req_origin_x);
         req_item.opnd_b = 33'(req_point_y) - 33'(req_origin_y);
      end
   end

   plf_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept),
      .in_angle  (req_origin_angle),
      .in_item   (req_item),
      .out_valid (cd_valid),
      .out_cos   (cd_cos),
      .out_sin   (cd_sin),
      .out_item  (cd_item)
   );

   assign mul_valid_in = cd_valid;
   assign prod_ac_in   = cd_item.opnd_a * cd_cos;
   assign prod_bs_in   = cd_item.opnd_b * cd_sin;
   assign prod_as_in   = cd_item.opnd_a * cd_sin;
   assign prod_bc_in   = cd_item.opnd_b * cd_cos;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= mul_valid_in;
      end
      mul_world_ff <= cd_item.to_world;
      mul_ox_ff    <= cd_item.origin_x;
      mul_oy_ff    <= cd_item.origin_y;
      prod_ac_ff   <= prod_ac_in;
      prod_bs_ff   <= prod_bs_in;
      prod_as_ff   <= prod_as_in;
      prod_bc_ff   <= prod_bc_in;
   end

   // to world: rotate by +heading; to local: rotate by -heading
   always_comb begin
      if (mul_world_ff) begin
         sum_x = 66'(prod_ac_ff) - 66'(prod_bs_ff);
         sum_y = 66'(prod_bc_ff) + 66'(prod_as_ff);
      end else begin
         sum_x = 66'(prod_ac_ff) + 66'(prod_bs_ff);
         sum_y = 66'(prod_bc_ff) - 66'(prod_as_ff);
      end
      rnd_x = sum_x + ROUND_HALF;
      rnd_y = sum_y + ROUND_HALF;
   end

   assign sum_valid_in = mul_valid_ff;
   assign rnd_x_in     = rnd_x[65:30];
   assign rnd_y_in     = rnd_y[65:30];

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else begin
         sum_valid_ff <= sum_valid_in;
      end
      sum_world_ff <= mul_world_ff;
      sum_ox_ff    <= mul_ox_ff;
      sum_oy_ff    <= mul_oy_ff;
      rnd_x_ff     <= rnd_x_in;
      rnd_y_ff     <= rnd_y_in;
   end

   always_comb begin
      if (sum_world_ff) begin
         ext_x = 37'(rnd_x_ff) + 37'(sum_ox_ff);
         ext_y = 37'(rnd_y_ff) + 37'(sum_oy_ff);
      end else begin
         ext_x = 37'(rnd_x_ff);
         ext_y = 37'(rnd_y_ff);
      end
      ovf_x = (ext_x > SAT_MAX) || (ext_x < SAT_MIN);
      ovf_y = (ext_y > SAT_MAX) || (ext_y < SAT_MIN);
      if (ext_x > SAT_MAX) begin
         out_x_in = SAT_MAX[31:0];
      end else if (ext_x < SAT_MIN) begin
         out_x_in = SAT_MIN[31:0];
      end else begin
         out_x_in = ext_x[31:0];
      end
      if (ext_y > SAT_MAX) begin
         out_y_in = SAT_MAX[31:0];
      end else if (ext_y < SAT_MIN) begin
         out_y_in = SAT_MIN[31:0];
      end else begin
         out_y_in = ext_y[31:0];
      end
   end

   assign out_valid_in = sum_valid_ff;
   assign out_ovf_in   = ovf_x | ovf_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_x_ff   <= out_x_in;
      out_y_ff   <= out_y_in;
      out_ovf_ff <= out_ovf_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_result_x = out_x_ff;
   assign rsp_result_y = out_y_ff;
   assign rsp_overflow = out_ovf_ff;

endmodule

[design/plf_cordic.sv]
module plf_cordic (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [15:0]       in_angle,
   input  plf_pkg::item_type in_item,
   output logic              out_valid,
   output logic signed [31:0] out_cos,
   output logic signed [31:0] out_sin,
   output plf_pkg::item_type out_item
);
   import plf_pkg::*;

   logic               valid_ff [CORDIC_STAGES+1];
   logic               valid_in [CORDIC_STAGES+1];
   logic               flip_ff  [CORDIC_STAGES+1];
   logic               flip_in  [CORDIC_STAGES+1];
   logic signed [31:0] x_ff     [CORDIC_STAGES+1];
   logic signed [31:0] x_in     [CORDIC_STAGES+1];
   logic signed [31:0] y_ff     [CORDIC_STAGES+1];
   logic signed [31:0] y_in     [CORDIC_STAGES+1];
   logic signed [31:0] z_ff     [CORDIC_STAGES+1];
   logic signed [31:0] z_in     [CORDIC_STAGES+1];
   item_type           item_ff  [CORDIC_STAGES+1];
   item_type           item_in  [CORDIC_STAGES+1];

   logic               valid_out_ff, valid_out_in;
   logic signed [31:0] cos_ff, cos_in;
   logic signed [31:0] sin_ff, sin_in;
   item_type           item_out_ff, item_out_in;

   // load: headings outside [-pi/2, pi/2) are turned by pi, result negated later
   assign flip_in[0]  = in_angle[15] ^ in_angle[14];
   assign valid_in[0] = in_valid;
   assign x_in[0]     = CORDIC_GAIN_INV;
   assign y_in[0]     = '0;
   assign z_in[0]     = {in_angle[15] ^ flip_in[0], in_angle[14:0], 16'h0000};
   assign item_in[0]  = in_item;

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_step
      logic signed [31:0] xs, ys;
      assign xs = x_ff[i] >>> i;
      assign ys = y_ff[i] >>> i;
      assign valid_in[i+1] = valid_ff[i];
      assign flip_in[i+1]  = flip_ff[i];
      assign item_in[i+1]  = item_ff[i];
      assign x_in[i+1] = z_ff[i][31] ? x_ff[i] + ys : x_ff[i] - ys;
      assign y_in[i+1] = z_ff[i][31] ? y_ff[i] - xs : y_ff[i] + xs;
      assign z_in[i+1] = z_ff[i][31] ? z_ff[i] + ATAN_TABLE[i] : z_ff[i] - ATAN_TABLE[i];
   end

   for (genvar k = 0; k <= CORDIC_STAGES; k++) begin : g_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_in[k];
         end
         flip_ff[k] <= flip_in[k];
         x_ff[k]    <= x_in[k];
         y_ff[k]    <= y_in[k];
         z_ff[k]    <= z_in[k];
         item_ff[k] <= item_in[k];
      end
   end

   assign valid_out_in = valid_ff[CORDIC_STAGES];
   assign cos_in = flip_ff[CORDIC_STAGES] ? -x_ff[CORDIC_STAGES] : x_ff[CORDIC_STAGES];
   assign sin_in = flip_ff[CORDIC_STAGES] ? -y_ff[CORDIC_STAGES] : y_ff[CORDIC_STAGES];
   assign item_out_in = item_ff[CORDIC_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_out_ff <= 1'b0;
      end else begin
         valid_out_ff <= valid_out_in;
      end
      cos_ff      <= cos_in;
      sin_ff      <= sin_in;
      item_out_ff <= item_out_in;
   end

   assign out_valid = valid_out_ff;
   assign out_cos   = cos_ff;
   assign out_sin   = sin_ff;
   assign out_item  = item_out_ff;

endmodule

[verif/plf_result_checker.sv]
module plf_result_checker
   import plf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic               req_command,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_origin_x,
   input  logic signed [31:0] req_origin_y,
   input  logic signed [15:0] req_origin_angle,
   input  logic               rsp_valid,
   input  logic signed [31:0] rsp_result_x,
   input  logic signed [31:0] rsp_result_y,
   input  logic               rsp_overflow,
   output int                 mismatch_count,
   output int                 pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      command_type        command;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [15:0] heading;
   } frame_request_type;

   typedef struct packed {
      logic signed [31:0] res_x;
      logic signed [31:0] res_y;
      logic               overflow;
   } frame_result_type;

   frame_result_type expected_points [$];

   initial begin
      mismatch_count  = 0;
      pending_results = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   // rigid transform with a CORDIC sine/cosine of the heading
   function automatic frame_result_type transform_point(input frame_request_type rq);
      logic [31:0]        z_ang;
      logic               fold;
      longint             cos_v, sin_v, z, cos_sh, sin_sh;
      int                 i, k;
      logic signed [71:0] c72, s72, ax, ay, sum_x, sum_y;
      logic signed [71:0] raw [2];
      logic signed [31:0] sat [2];
      frame_result_type   res;
      // headings outside [-pi/2, pi/2) are turned by pi and the result negated
      z_ang = {rq.heading, 16'h0000};
      fold  = rq.heading[15] ^ rq.heading[14];
      if (fold) begin
         z_ang = z_ang + 32'h8000_0000;
      end
      z     = longint'($signed(z_ang));
      cos_v = longint'(CORDIC_GAIN_INV);
      sin_v = 0;
      for (i = 0; i < ROTATION_STEPS && i < ATAN_ENTRIES; i++) begin
         cos_sh = cos_v >>> i;
         sin_sh = sin_v >>> i;
         if (z >= 0) begin
            cos_v = cos_v - sin_sh;
            sin_v = sin_v + cos_sh;
            z     = z - longint'(ATAN_TABLE[i]);
         end else begin
            cos_v = cos_v + sin_sh;
            sin_v = sin_v - cos_sh;
            z     = z + longint'(ATAN_TABLE[i]);
         end
      end
      if (fold) begin
         cos_v = -cos_v;
         sin_v = -sin_v;
      end
      c72 = cos_v;
      s72 = sin_v;
      ax  = rq.point_x;
      ay  = rq.point_y;
      if (rq.command == CMD_TO_WORLD) begin
         sum_x = ax * c72 - ay * s72;
         sum_y = ax * s72 + ay * c72;
      end else begin
         ax    = ax - rq.origin_x;
         ay    = ay - rq.origin_y;
         sum_x = ax * c72 + ay * s72;
         sum_y = ay * c72 - ax * s72;
      end
      // round half up from Q.46 products down to Q15.16
      raw[0] = (sum_x + 72'sd536870912) >>> 30;
      raw[1] = (sum_y + 72'sd536870912) >>> 30;
      if (rq.command == CMD_TO_WORLD) begin
         raw[0] = raw[0] + rq.origin_x;
         raw[1] = raw[1] + rq.origin_y;
      end
      res.overflow = 1'b0;
      for (k = 0; k < 2; k++) begin
         if (raw[k] > 72'sd2147483647) begin
            sat[k]       = 32'sh7FFF_FFFF;
            res.overflow = 1'b1;
         end else if (raw[k] < -72'sd2147483648) begin
            sat[k]       = 32'sh8000_0000;
            res.overflow = 1'b1;
         end else begin
            sat[k] = raw[k][31:0];
         end
      end
      res.res_x = sat[0];
      res.res_y = sat[1];
      return res;
   endfunction

   always @(posedge clock) begin
      frame_result_type  got, want;
      frame_request_type rq;
      if (!reset) begin
         if (rsp_valid) begin
            got.res_x    = rsp_result_x;
            got.res_y    = rsp_result_y;
            got.overflow = rsp_overflow;
            if (expected_points.size() == 0) begin
               report_mismatch($sformatf("result with no request outstanding: %h %h %b",
                                         got.res_x, got.res_y, got.overflow));
            end else begin
               want = expected_points.pop_front();
               if (got.res_x !== want.res_x) begin
                  report_mismatch($sformatf("result_x got %h expected %h",
                                            got.res_x, want.res_x));
               end
               if (got.res_y !== want.res_y) begin
                  report_mismatch($sformatf("result_y got %h expected %h",
                                            got.res_y, want.res_y));
               end
               if (got.overflow !== want.overflow) begin
                  report_mismatch($sformatf("overflow got %b expected %b",
                                            got.overflow, want.overflow));
               end
            end
         end
         if (start && !busy) begin
            rq.command  = command_type'(req_command);
            rq.point_x  = req_point_x;
            rq.point_y  = req_point_y;
            rq.origin_x = req_origin_x;
            rq.origin_y = req_origin_y;
            rq.heading  = req_origin_angle;
            expected_points.push_back(transform_point(rq));
         end
      end
      pending_results <= expected_points.size();
   end

endmodule

[verif/tb_planar_frame_transform.sv]
module tb_planar_frame_transform;
   timeunit 1ns;
   timeprecision 1ps;
   import plf_pkg::*;

   localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] ONE_M     = 32'sh0001_0000;
   localparam logic signed [15:0] HEAD_PI   = 16'sh8000;
   localparam logic signed [15:0] HEAD_MAX  = 16'sh7FFF;
   localparam logic signed [15:0] HEAD_QTR  = 16'sh4000;
   localparam logic signed [15:0] HEAD_8TH  = 16'sh2000;
   localparam int                 PHASE_REQUESTS = 275;

   logic               clock            = 1'b0;
   logic               reset            = 1'b1;
   logic               start            = 1'b0;
   logic               req_command      = 1'b0;
   logic signed [31:0] req_point_x      = '0;
   logic signed [31:0] req_point_y      = '0;
   logic signed [31:0] req_origin_x     = '0;
   logic signed [31:0] req_origin_y     = '0;
   logic signed [15:0] req_origin_angle = '0;
   logic               busy;
   logic               rsp_valid;
   logic signed [31:0] rsp_result_x;
   logic signed [31:0] rsp_result_y;
   logic               rsp_overflow;
   int                 mismatch_count;
   int                 pending_results;
   int                 sender_idle_pct  = 0;

   always begin
      #10;
      clock = 1'b1;
      #10;
      clock = 1'b0;
   end

   planar_frame_transform i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_origin_x     (req_origin_x),
      .req_origin_y     (req_origin_y),
      .req_origin_angle (req_origin_angle),
      .rsp_valid        (rsp_valid),
      .rsp_result_x     (rsp_result_x),
      .rsp_result_y     (rsp_result_y),
      .rsp_overflow     (rsp_overflow)
   );

   plf_result_checker u_result_check (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_origin_x     (req_origin_x),
      .req_origin_y     (req_origin_y),
      .req_origin_angle (req_origin_angle),
      .rsp_valid        (rsp_valid),
      .rsp_result_x     (rsp_result_x),
      .rsp_result_y     (rsp_result_y),
      .rsp_overflow     (rsp_overflow),
      .mismatch_count   (mismatch_count),
      .pending_results  (pending_results)
   );

   // called at a rising edge; returns at the edge that takes the request
   task automatic send_request(input command_type        cmd,
                               input logic signed [31:0] px,
                               input logic signed [31:0] py,
                               input logic signed [31:0] ox,
                               input logic signed [31:0] oy,
                               input logic signed [15:0] hd);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start            <= 1'b1;
      req_command      <= cmd;
      req_point_x      <= px;
      req_point_y      <= py;
      req_origin_x     <= ox;
      req_origin_y     <= oy;
      req_origin_angle <= hd;
      // busy only moves on rising edges, so the falling edge gives a clean look
      @(negedge clock);
      while (busy) begin
         @(negedge clock);
      end
      @(posedge clock);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      @(negedge clock);
      while (pending_results != 0) begin
         @(negedge clock);
      end
      @(posedge clock);
   endtask

   function automatic logic signed [31:0] random_coord();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(3))
         0, 1: return r;
         2: return $signed({{12{r[19]}}, r[19:0]});
         default: begin
            case (r[1:0])
               2'd0: return COORD_MAX;
               2'd1: return COORD_MIN;
               2'd2: return '0;
               default: return -32'sd1;
            endcase
         end
      endcase
   endfunction

   function automatic logic signed [15:0] random_heading();
      logic [15:0] r;
      r = 16'($urandom);
      if ($urandom_range(7) != 0) begin
         return r;
      end
      case (r[2:0])
         3'd0: return HEAD_PI;
         3'd1: return HEAD_MAX;
         3'd2: return HEAD_QTR;
         3'd3: return -HEAD_QTR;
         3'd4: return HEAD_8TH;
         3'd5: return -16'sd1;
         default: return '0;
      endcase
   endfunction

   initial begin
      int phase_idle [4];
      int p, n;
      phase_idle = '{0, 69, 25, 0};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: quadrant edges, extreme heading, saturation in both senses
      send_request(CMD_TO_LOCAL, '0, '0, '0, '0, '0);
      send_request(CMD_TO_WORLD, '0, '0, '0, '0, '0);
      send_request(CMD_TO_LOCAL, ONE_M, 2 * ONE_M, '0, '0, HEAD_QTR);
      send_request(CMD_TO_WORLD, ONE_M, 2 * ONE_M, ONE_M, -ONE_M, -HEAD_QTR);
      send_request(CMD_TO_LOCAL, 3 * ONE_M, -ONE_M, ONE_M, ONE_M, HEAD_PI);
      send_request(CMD_TO_WORLD, 3 * ONE_M, -ONE_M, -ONE_M, ONE_M, HEAD_PI);
      send_request(CMD_TO_WORLD, -ONE_M, ONE_M, '0, '0, HEAD_MAX);
      send_request(CMD_TO_LOCAL, ONE_M, ONE_M, '0, '0, HEAD_8TH);
      send_request(CMD_TO_WORLD, ONE_M, ONE_M, '0, '0, -HEAD_8TH);
      send_request(CMD_TO_LOCAL, ONE_M, '0, '0, '0, HEAD_QTR - 16'sd1);
      send_request(CMD_TO_WORLD, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, '0);
      send_request(CMD_TO_WORLD, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, '0);
      send_request(CMD_TO_LOCAL, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, '0);
      send_request(CMD_TO_LOCAL, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, HEAD_QTR);
      send_request(CMD_TO_WORLD, COORD_MAX, COORD_MIN, '0, '0, HEAD_8TH);
      send_request(CMD_TO_LOCAL, COORD_MAX, COORD_MAX, '0, '0, HEAD_PI);
      send_request(CMD_TO_WORLD, COORD_MIN, COORD_MAX, '0, '0, HEAD_MAX);
      send_request(CMD_TO_WORLD, 32'sd1, 32'sd1, '0, '0, 16'sd12345);
      send_request(CMD_TO_LOCAL, -32'sd1, -32'sd1, '0, '0, 16'sh6000);
      send_request(CMD_TO_WORLD, '0, '0, COORD_MAX, COORD_MIN, 16'sh1000);
      send_request(CMD_TO_LOCAL, '0, '0, -32'sd1, 32'sd1, -16'sd1);
      send_request(CMD_TO_LOCAL, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, -HEAD_8TH);

      for (p = 0; p < 4; p++) begin
         sender_idle_pct = phase_idle[p];
         for (n = 0; n < PHASE_REQUESTS; n++) begin
            send_request(command_type'($urandom_range(1)), random_coord(), random_coord(),
                         random_coord(), random_coord(), random_heading());
         end
         // hold off until the pipeline is empty before the next phase
         drain_results();
      end

      repeat (ROTATION_STEPS + 12) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("planar_frame_transform regression: pass");
      end else begin
         $display("planar_frame_transform regression: fail");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d results outstanding", pending_results);
      $display("planar_frame_transform regression: fail");
      $finish;
   end

endmodule
